@@ design/sfc_pkg.sv @@
`timescale 1ns / 1ps
// sfc_pkg: shared constants, register indexes and types for the sphere cull core.
// No dependencies; imported by sfc_xform_lane, sphere_frustum_cull_test_core and tb.
package sfc_pkg;

    // default field widths
    localparam int POS_WIDTH_DEF  = 20;
    localparam int COEF_WIDTH_DEF = 16;

    // config port
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 3;
    localparam int NUM_CFG_REGS = 7;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    typedef logic [CFG_DATA_W-1:0] t_cfg_word;

    localparam t_cfg_addr REG_ROT_COL_X      = 3'd0;
    localparam t_cfg_addr REG_ROT_COL_Y      = 3'd1;
    localparam t_cfg_addr REG_ROT_COL_Z      = 3'd2;
    localparam t_cfg_addr REG_VIEW_TRANS     = 3'd3;
    localparam t_cfg_addr REG_SIDE_PLANES_LR = 3'd4;
    localparam t_cfg_addr REG_SIDE_PLANES_TB = 3'd5;
    localparam t_cfg_addr REG_NEAR_FAR       = 3'd6;

    // reset values: identity rotation, everything else zero
    localparam t_cfg_word ROT_COL_X_RST      = 64'h0000_0000_0000_4000;
    localparam t_cfg_word ROT_COL_Y_RST      = 64'h0000_0000_4000_0000;
    localparam t_cfg_word ROT_COL_Z_RST      = 64'h0000_4000_0000_0000;
    localparam t_cfg_word VIEW_TRANS_RST     = 64'h0;
    localparam t_cfg_word SIDE_PLANES_LR_RST = 64'h0;
    localparam t_cfg_word SIDE_PLANES_TB_RST = 64'h0;
    localparam t_cfg_word NEAR_FAR_RST       = 64'h0;

    // output beat is the single visible flag, padded to a byte
    localparam int OUT_TDATA_W = 8;

    // load enables for the three transform stages inside a lane
    typedef struct packed {
        logic en_s1;
        logic en_s2;
        logic en_s3;
    } t_lane_ctl;

endpackage

@@ design/sphere_frustum_cull_test_core.sv @@
`timescale 1ns / 1ps
// sphere_frustum_cull_test_core: top level of the sphere vs. view frustum cull test.
// Depends on sfc_pkg and sfc_xform_lane.
//
//  channel   dir  beat contents (low bit first)               handshake
//  s_axis    in   tdata: pos_x, pos_y, pos_z, radius, pad    tvalid/tready
//                 tuser: in_view_space
//  m_axis    out  tdata: visible, pad to 8 bits               tvalid/tready
//  cfg       in   i_cfg_addr selects register, i_cfg_data     i_cfg_wr_en, no wait
//
// Five register stages: three in the transform lanes (products, partial
// sums, final sum with view-space bypass and z negate), one for the plane
// products and near/far checks, one for the plane compares, which is also
// the output register. One sphere per cycle while the output is not stalled.
// Each stage loads when it is empty or the stage after it moves, so a
// downstream stall backs up stage by stage and bubbles are squeezed out.
// Reset (synchronous, active low) clears the valid bits and loads the
// register defaults: identity rotation, zero translation, planes and range.
module sphere_frustum_cull_test_core #(
    parameter int POS_WIDTH  = sfc_pkg::POS_WIDTH_DEF,
    parameter int COEF_WIDTH = sfc_pkg::COEF_WIDTH_DEF,
    localparam int IN_TDATA_W = ((4 * POS_WIDTH - 1 + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write port
    input  logic                         i_cfg_wr_en,
    input  sfc_pkg::t_cfg_addr           i_cfg_addr,
    input  sfc_pkg::t_cfg_word           i_cfg_data,
    // sphere input
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // pos_x, pos_y, pos_z, radius (POS_WIDTH-1), zero pad
    input  logic [IN_TDATA_W-1:0]        s_axis_tdata,
    // in_view_space
    input  logic [0:0]                   s_axis_tuser,
    // result output
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // visible, zero pad
    output logic [sfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import sfc_pkg::*;

    localparam int FRAC   = COEF_WIDTH - 2;
    localparam int RW     = POS_WIDTH - 1;            // radius width
    localparam int VW     = POS_WIDTH + COEF_WIDTH + 1; // view coordinate
    localparam int NW     = VW + 1;                   // near/far sums
    localparam int MW     = VW + COEF_WIDTH;          // plane products
    localparam int SW     = MW + 1;                   // plane sums
    // slices may run past the 64-bit word at wide settings: read as zero
    localparam int CPAD_W = CFG_DATA_W + 4 * COEF_WIDTH;
    localparam int TPAD_W = CFG_DATA_W + 3 * POS_WIDTH;

    // ---------------- config registers ----------------
    t_cfg_word r_cfg [NUM_CFG_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ROT_COL_X]      <= ROT_COL_X_RST;
            r_cfg[REG_ROT_COL_Y]      <= ROT_COL_Y_RST;
            r_cfg[REG_ROT_COL_Z]      <= ROT_COL_Z_RST;
            r_cfg[REG_VIEW_TRANS]     <= VIEW_TRANS_RST;
            r_cfg[REG_SIDE_PLANES_LR] <= SIDE_PLANES_LR_RST;
            r_cfg[REG_SIDE_PLANES_TB] <= SIDE_PLANES_TB_RST;
            r_cfg[REG_NEAR_FAR]       <= NEAR_FAR_RST;
        end else if (i_cfg_wr_en && (int'(i_cfg_addr) < NUM_CFG_REGS)) begin
            r_cfg[i_cfg_addr] <= i_cfg_data;
        end
    end

    logic [CPAD_W-1:0] w_rx_pad, w_ry_pad, w_rz_pad, w_lr_pad, w_tb_pad;
    logic [TPAD_W-1:0] w_tr_pad, w_nf_pad;

    assign w_rx_pad = CPAD_W'(r_cfg[REG_ROT_COL_X]);
    assign w_ry_pad = CPAD_W'(r_cfg[REG_ROT_COL_Y]);
    assign w_rz_pad = CPAD_W'(r_cfg[REG_ROT_COL_Z]);
    assign w_lr_pad = CPAD_W'(r_cfg[REG_SIDE_PLANES_LR]);
    assign w_tb_pad = CPAD_W'(r_cfg[REG_SIDE_PLANES_TB]);
    assign w_tr_pad = TPAD_W'(r_cfg[REG_VIEW_TRANS]);
    assign w_nf_pad = TPAD_W'(r_cfg[REG_NEAR_FAR]);

    logic signed [COEF_WIDTH-1:0] w_lx, w_lz, w_rx, w_rz, w_ty, w_tz, w_by, w_bz;
    logic signed [POS_WIDTH-1:0]  w_near, w_far;

    assign w_lx   = w_lr_pad[0*COEF_WIDTH +: COEF_WIDTH];
    assign w_lz   = w_lr_pad[1*COEF_WIDTH +: COEF_WIDTH];
    assign w_rx   = w_lr_pad[2*COEF_WIDTH +: COEF_WIDTH];
    assign w_rz   = w_lr_pad[3*COEF_WIDTH +: COEF_WIDTH];
    assign w_ty   = w_tb_pad[0*COEF_WIDTH +: COEF_WIDTH];
    assign w_tz   = w_tb_pad[1*COEF_WIDTH +: COEF_WIDTH];
    assign w_by   = w_tb_pad[2*COEF_WIDTH +: COEF_WIDTH];
    assign w_bz   = w_tb_pad[3*COEF_WIDTH +: COEF_WIDTH];
    assign w_near = w_nf_pad[0*POS_WIDTH +: POS_WIDTH];
    assign w_far  = w_nf_pad[1*POS_WIDTH +: POS_WIDTH];

    // ---------------- stage control ----------------
    logic [5:1] r_v;
    logic [5:1] w_en;

    // a stage takes a new beat when empty or when its content moves on
    assign w_en[5] = !r_v[5] || m_axis_tready;
    assign w_en[4] = !r_v[4] || w_en[5];
    assign w_en[3] = !r_v[3] || w_en[4];
    assign w_en[2] = !r_v[2] || w_en[3];
    assign w_en[1] = !r_v[1] || w_en[2];

    assign s_axis_tready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= s_axis_tvalid;
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
            if (w_en[4]) r_v[4] <= r_v[3];
            if (w_en[5]) r_v[5] <= r_v[4];
        end
    end

    // ---------------- input unpack ----------------
    logic signed [POS_WIDTH-1:0] w_pos_x, w_pos_y, w_pos_z;
    logic [RW-1:0]               w_radius;
    logic                        w_view;

    assign w_pos_x  = s_axis_tdata[0*POS_WIDTH +: POS_WIDTH];
    assign w_pos_y  = s_axis_tdata[1*POS_WIDTH +: POS_WIDTH];
    assign w_pos_z  = s_axis_tdata[2*POS_WIDTH +: POS_WIDTH];
    assign w_radius = s_axis_tdata[3*POS_WIDTH +: RW];
    assign w_view   = s_axis_tuser[0];

    // ---------------- stages 1..3: transform lanes ----------------
    t_lane_ctl w_lane_ctl;
    assign w_lane_ctl = '{en_s1: w_en[1], en_s2: w_en[2], en_s3: w_en[3]};

    logic signed [VW-1:0] w_xv, w_yv, w_zv;

    sfc_xform_lane #(.POS_WIDTH(POS_WIDTH), .COEF_WIDTH(COEF_WIDTH), .NEGATE(1'b0)) u_lane_x (
        .i_clk     (i_clk),
        .i_ctl     (w_lane_ctl),
        .i_pos_x   (w_pos_x),
        .i_pos_y   (w_pos_y),
        .i_pos_z   (w_pos_z),
        .i_pos_own (w_pos_x),
        .i_view    (w_view),
        .i_coef_x  (w_rx_pad[0*COEF_WIDTH +: COEF_WIDTH]),
        .i_coef_y  (w_rx_pad[1*COEF_WIDTH +: COEF_WIDTH]),
        .i_coef_z  (w_rx_pad[2*COEF_WIDTH +: COEF_WIDTH]),
        .i_trans   (w_tr_pad[0*POS_WIDTH +: POS_WIDTH]),
        .o_coord   (w_xv)
    );

    sfc_xform_lane #(.POS_WIDTH(POS_WIDTH), .COEF_WIDTH(COEF_WIDTH), .NEGATE(1'b0)) u_lane_y (
        .i_clk     (i_clk),
        .i_ctl     (w_lane_ctl),
        .i_pos_x   (w_pos_x),
        .i_pos_y   (w_pos_y),
        .i_pos_z   (w_pos_z),
        .i_pos_own (w_pos_y),
        .i_view    (w_view),
        .i_coef_x  (w_ry_pad[0*COEF_WIDTH +: COEF_WIDTH]),
        .i_coef_y  (w_ry_pad[1*COEF_WIDTH +: COEF_WIDTH]),
        .i_coef_z  (w_ry_pad[2*COEF_WIDTH +: COEF_WIDTH]),
        .i_trans   (w_tr_pad[1*POS_WIDTH +: POS_WIDTH]),
        .o_coord   (w_yv)
    );

    // z lane hands out the forward distance (view z negated)
    sfc_xform_lane #(.POS_WIDTH(POS_WIDTH), .COEF_WIDTH(COEF_WIDTH), .NEGATE(1'b1)) u_lane_z (
        .i_clk     (i_clk),
        .i_ctl     (w_lane_ctl),
        .i_pos_x   (w_pos_x),
        .i_pos_y   (w_pos_y),
        .i_pos_z   (w_pos_z),
        .i_pos_own (w_pos_z),
        .i_view    (w_view),
        .i_coef_x  (w_rz_pad[0*COEF_WIDTH +: COEF_WIDTH]),
        .i_coef_y  (w_rz_pad[1*COEF_WIDTH +: COEF_WIDTH]),
        .i_coef_z  (w_rz_pad[2*COEF_WIDTH +: COEF_WIDTH]),
        .i_trans   (w_tr_pad[2*POS_WIDTH +: POS_WIDTH]),
        .o_coord   (w_zv)
    );

    // radius rides alongside the lanes
    logic [RW-1:0] r_rad1, r_rad2, r_rad3, r_rad4;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) r_rad1 <= w_radius;
        if (w_en[2]) r_rad2 <= r_rad1;
        if (w_en[3]) r_rad3 <= r_rad2;
        if (w_en[4]) r_rad4 <= r_rad3;
    end

    // ---------------- stage 4: plane products, near/far ----------------
    logic signed [MW-1:0] r_lx, r_lz, r_rx, r_rz, r_ty, r_tz, r_by, r_bz;
    logic                 r_near_rej, r_far_rej;

    logic signed [POS_WIDTH-1:0] w_rad3_s;
    logic signed [NW-1:0]        w_rad3_sh, w_near_sh, w_far_sh;
    logic signed [NW-1:0]        w_z_plus_r, w_z_minus_r;

    always_comb begin
        w_rad3_s    = $signed({1'b0, r_rad3});
        w_rad3_sh   = NW'(w_rad3_s) <<< FRAC;
        w_near_sh   = NW'(w_near) <<< FRAC;
        w_far_sh    = NW'(w_far) <<< FRAC;
        w_z_plus_r  = NW'(w_zv) + w_rad3_sh;
        w_z_minus_r = NW'(w_zv) - w_rad3_sh;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_lx       <= MW'(w_xv) * MW'(w_lx);
            r_lz       <= MW'(w_zv) * MW'(w_lz);
            r_rx       <= MW'(w_xv) * MW'(w_rx);
            r_rz       <= MW'(w_zv) * MW'(w_rz);
            r_ty       <= MW'(w_yv) * MW'(w_ty);
            r_tz       <= MW'(w_zv) * MW'(w_tz);
            r_by       <= MW'(w_yv) * MW'(w_by);
            r_bz       <= MW'(w_zv) * MW'(w_bz);
            r_near_rej <= (w_z_plus_r < w_near_sh);
            r_far_rej  <= (w_z_minus_r > w_far_sh);
        end
    end

    // ---------------- stage 5: plane compares, output register ----------------
    logic signed [POS_WIDTH-1:0] w_rad4_s;
    logic signed [SW-1:0]        w_rs;
    logic                        w_side_rej;
    logic                        r_vis;

    always_comb begin
        w_rad4_s   = $signed({1'b0, r_rad4});
        w_rs       = SW'(w_rad4_s) <<< (2 * FRAC);
        // equality on a plane still passes
        w_side_rej = ((SW'(r_lx) + SW'(r_lz)) > w_rs)
                  || ((SW'(r_rx) + SW'(r_rz)) > w_rs)
                  || ((SW'(r_ty) + SW'(r_tz)) > w_rs)
                  || ((SW'(r_by) + SW'(r_bz)) > w_rs);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_vis <= !(r_near_rej || r_far_rej || w_side_rej);
        end
    end

    assign m_axis_tvalid = r_v[5];
    assign m_axis_tdata  = OUT_TDATA_W'(r_vis);

    // ---------------- assertions ----------------
    // a stalled stage 4 keeps its beat and its near check
    a_stage4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] && !w_en[4] |=> r_v[4] && $stable(r_near_rej) && $stable(r_lz))
        else $error("stage 4 lost or changed a stalled beat");

    // a taken result with nothing behind it leaves the output empty
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !r_v[4] |=> !m_axis_tvalid)
        else $error("result appeared without a beat behind it");

    // accepted beat always lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v[1])
        else $error("accepted beat did not enter stage 1");

    // reset restores the identity z column
    a_reset_cfg: assert property (@(posedge i_clk)
        !i_rst_n |=> r_cfg[REG_ROT_COL_Z] == ROT_COL_Z_RST)
        else $error("config reset value wrong");

endmodule

@@ design/sfc_xform_lane.sv @@
`timescale 1ns / 1ps
// sfc_xform_lane: one view-space coordinate, three register stages
// (products, partial sums, final sum / bypass / optional negate). Uses sfc_pkg.
module sfc_xform_lane #(
    parameter int POS_WIDTH  = sfc_pkg::POS_WIDTH_DEF,
    parameter int COEF_WIDTH = sfc_pkg::COEF_WIDTH_DEF,
    parameter bit NEGATE     = 1'b0
) (
    input  logic                                 i_clk,
    input  sfc_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [POS_WIDTH-1:0]          i_pos_x,
    input  logic signed [POS_WIDTH-1:0]          i_pos_y,
    input  logic signed [POS_WIDTH-1:0]          i_pos_z,
    input  logic signed [POS_WIDTH-1:0]          i_pos_own,
    input  logic                                 i_view,
    input  logic signed [COEF_WIDTH-1:0]         i_coef_x,
    input  logic signed [COEF_WIDTH-1:0]         i_coef_y,
    input  logic signed [COEF_WIDTH-1:0]         i_coef_z,
    input  logic signed [POS_WIDTH-1:0]          i_trans,
    output logic signed [POS_WIDTH+COEF_WIDTH:0] o_coord
);
    import sfc_pkg::*;

    localparam int FRAC = COEF_WIDTH - 2;
    localparam int PW   = POS_WIDTH + COEF_WIDTH;
    localparam int VW   = PW + 1;

    // stage 1
    logic signed [PW-1:0]        r_p0, r_p1, r_p2;
    logic signed [POS_WIDTH-1:0] r_own1;
    logic                        r_view1;
    // stage 2
    logic signed [VW-1:0]        r_s01, r_s2t;
    logic signed [POS_WIDTH-1:0] r_own2;
    logic                        r_view2;
    // stage 3
    logic signed [VW-1:0]        r_coord;

    logic signed [VW-1:0] n_sel;
    logic signed [VW-1:0] n_coord;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s1) begin
            r_p0    <= PW'(i_coef_x) * PW'(i_pos_x);
            r_p1    <= PW'(i_coef_y) * PW'(i_pos_y);
            r_p2    <= PW'(i_coef_z) * PW'(i_pos_z);
            r_own1  <= i_pos_own;
            r_view1 <= i_view;
        end
        if (i_ctl.en_s2) begin
            r_s01   <= VW'(r_p0) + VW'(r_p1);
            // translation must stay static while beats are in flight; the lane does not enforce it
            r_s2t   <= VW'(r_p2) + (VW'(i_trans) <<< FRAC);
            r_own2  <= r_own1;
            r_view2 <= r_view1;
        end
        if (i_ctl.en_s3) begin
            r_coord <= n_coord;
        end
    end

    always_comb begin
        if (r_view2) begin
            n_sel = VW'(r_own2) <<< FRAC;
        end else begin
            n_sel = r_s01 + r_s2t;
        end
        n_coord = NEGATE ? -n_sel : n_sel;
    end

    assign o_coord = r_coord;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for sphere_frustum_cull_test_core (visible flag per sphere beat).
// Depends on sfc_pkg and the core; checks each beat against an in-bench cull predictor.
module tb;
    import sfc_pkg::*;

    localparam int          COEF_FRAC         = COEF_WIDTH_DEF - 2;
    localparam int          IN_TDATA_W        = ((4 * POS_WIDTH_DEF - 1 + 7) / 8) * 8;
    localparam int          SETTLE_CYCLES     = 8;
    localparam int          SETTINGS_PER_PH   = 5;
    localparam int          ITEMS_PER_SETTING = 90;
    localparam int unsigned CYCLE_LIMIT       = 400000;
    localparam int          DIR_ROWS          = 34;

    // register index past the end of the map; writes to it must be dropped
    localparam t_cfg_addr REG_OUT_OF_RANGE = t_cfg_addr'(NUM_CFG_REGS);

    typedef struct {
        logic signed [POS_WIDTH_DEF-1:0] pos_x;
        logic signed [POS_WIDTH_DEF-1:0] pos_y;
        logic signed [POS_WIDTH_DEF-1:0] pos_z;
        logic [POS_WIDTH_DEF-2:0]        radius;
        logic                            in_view;
    } t_sphere;

    typedef enum {WANT_MODEL, WANT_CULLED, WANT_SHOWN} t_verdict;
    typedef enum {ROW_SPHERE, ROW_CFG} t_row_kind;
    typedef enum {SET_TYPICAL, SET_RANDOM, SET_EXTREME} t_setting;

    typedef struct {
        t_row_kind kind;
        t_cfg_addr addr;
        t_cfg_word data;
        t_sphere   sph;
        t_verdict  want;
    } t_stim_row;

    // DUT pins; the ones the bench drives are known from time zero
    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_wr_en   = 1'b0;
    t_cfg_addr                  i_cfg_addr    = '0;
    t_cfg_word                  i_cfg_data    = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata  = '0;
    logic [0:0]                 s_axis_tuser  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;

    // bench-side copy of the register file
    t_cfg_word   cull_regs [NUM_CFG_REGS];
    int unsigned cfg_widths [NUM_CFG_REGS] = '{48, 48, 48, 60, 64, 64, 40};

    bit          pending_verdicts [$];   // visible flags still owed by the core
    bit          next_verdict;
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int unsigned cycle_count    = 0;
    int          send_idle_pct  = 9;
    int          recv_idle_pct  = 75;

    t_stim_row   directed_rows [DIR_ROWS];
    t_setting    phase_plan [SETTINGS_PER_PH] =
        '{SET_TYPICAL, SET_RANDOM, SET_TYPICAL, SET_EXTREME, SET_TYPICAL};

    sphere_frustum_cull_test_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake or a lost beat ends up here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d beats outstanding",
                 cycle_count, pending_verdicts.size());
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor. All products are kept exact in 64 bits:
    // view coords carry 8+14 fraction bits, plane sums 8+28.
    // ---------------------------------------------------------------
    function automatic longint coef_at(t_cfg_word w, int k);
        return longint'($signed(w[k*16 +: 16]));
    endfunction

    function automatic longint pos_at(t_cfg_word w, int k);
        return longint'($signed(w[k*20 +: 20]));
    endfunction

    // true when the plane pair's half-space distance exceeds the radius
    function automatic bit plane_rejects(t_cfg_word w, int pair, longint a, longint zv,
                                         longint rs);
        return a * coef_at(w, 2 * pair) + zv * coef_at(w, 2 * pair + 1) > rs;
    endfunction

    function automatic bit cull_verdict(t_sphere s);
        longint unit, rv, rs, nearv, farv;
        longint p [3];
        longint v [3];
        unit  = longint'(1) << COEF_FRAC;
        p[0]  = s.pos_x;
        p[1]  = s.pos_y;
        p[2]  = s.pos_z;
        rv    = longint'(s.radius) * unit;
        rs    = rv * unit;
        nearv = pos_at(cull_regs[REG_NEAR_FAR], 0) * unit;
        farv  = pos_at(cull_regs[REG_NEAR_FAR], 1) * unit;
        for (int c = 0; c < 3; c++) begin
            if (s.in_view) begin
                v[c] = p[c] * unit;
            end else begin
                // column c of the rotation gives view coordinate c
                v[c] = coef_at(cull_regs[c], 0) * p[0] + coef_at(cull_regs[c], 1) * p[1]
                     + coef_at(cull_regs[c], 2) * p[2]
                     + pos_at(cull_regs[REG_VIEW_TRANS], c) * unit;
            end
        end
        v[2] = -v[2];    // forward distance
        // equality passes every test
        return !(v[2] + rv < nearv || v[2] - rv > farv
                 || plane_rejects(cull_regs[REG_SIDE_PLANES_LR], 0, v[0], v[2], rs)
                 || plane_rejects(cull_regs[REG_SIDE_PLANES_LR], 1, v[0], v[2], rs)
                 || plane_rejects(cull_regs[REG_SIDE_PLANES_TB], 0, v[1], v[2], rs)
                 || plane_rejects(cull_regs[REG_SIDE_PLANES_TB], 1, v[1], v[2], rs));
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // ---------------------------------------------------------------
    // Output side: check each accepted beat, then re-roll tready.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing pending",
                                        results_seen));
            end else begin
                next_verdict = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== next_verdict) begin
                    flag_mismatch($sformatf("result %0d: visible %b, expected %b",
                                            results_seen, m_axis_tdata[0], next_verdict));
                end
            end
            results_seen++;
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    // Present one sphere beat, with random idle cycles ahead of it, and
    // queue its verdict once the core takes it. valid stays up between
    // back-to-back beats so it is never dropped and raised in one step.
    task automatic offer_sphere(t_sphere s, t_verdict want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, s.radius, s.pos_z, s.pos_y, s.pos_x};
        s_axis_tuser  <= s.in_view;
        do @(posedge i_clk); while (!s_axis_tready);
        case (want)
            WANT_CULLED: pending_verdicts.push_back(1'b0);
            WANT_SHOWN:  pending_verdicts.push_back(1'b1);
            default:     pending_verdicts.push_back(cull_verdict(s));
        endcase
    endtask

    // hold the input off until every owed beat is out and the pipe is empty
    task automatic park_inputs();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // caller drops the write enable after the last write of a batch
    task automatic cfg_write(t_cfg_addr addr, t_cfg_word data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (addr < NUM_CFG_REGS) begin
            cull_regs[addr] = data;
        end
    endtask

    function automatic logic [15:0] rand_coef(int lo, int hi);
        return 16'(int'($urandom_range(hi - lo)) + lo);
    endfunction

    task automatic load_setting(t_setting kind);
        t_cfg_word   w;
        int          near_d, far_d, tmp;
        logic [15:0] coef_edges [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000};
        logic [19:0] pos_edges [3]  = '{20'h80000, 20'h7FFFF, 20'h00000};
        park_inputs();
        for (int r = 0; r < NUM_CFG_REGS; r++) begin
            w = '0;
            case (kind)
                SET_RANDOM: begin
                    w = {$urandom, $urandom};
                end
                SET_EXTREME: begin
                    if (r == REG_VIEW_TRANS || r == REG_NEAR_FAR) begin
                        for (int sl = 0; sl < 3; sl++) begin
                            w[sl*20 +: 20] = pos_edges[$urandom_range(2)];
                        end
                    end else begin
                        for (int sl = 0; sl < 4; sl++) begin
                            w[sl*16 +: 16] = coef_edges[$urandom_range(4)];
                        end
                    end
                end
                default: begin
                    case (r)
                        REG_ROT_COL_X, REG_ROT_COL_Y, REG_ROT_COL_Z: begin
                            // near-orthonormal: strong diagonal, small cross terms
                            for (int sl = 0; sl < 3; sl++) begin
                                if (sl == r) begin
                                    w[sl*16 +: 16] = $urandom_range(1)
                                        ? rand_coef(16'h2000, 16'h4000)
                                        : -rand_coef(16'h2000, 16'h4000);
                                end else begin
                                    w[sl*16 +: 16] = rand_coef(-16'sh800, 16'sh800);
                                end
                            end
                        end
                        REG_VIEW_TRANS: begin
                            for (int sl = 0; sl < 3; sl++) begin
                                w[sl*20 +: 20] = 20'(int'($urandom_range(1 << 17)) - (1 << 16));
                            end
                        end
                        REG_SIDE_PLANES_LR, REG_SIDE_PLANES_TB: begin
                            // left/top lean negative, right/bottom positive, z terms negative
                            w[15:0]  = -rand_coef(16'h2000, 16'h6000);
                            w[31:16] = -rand_coef(16'h1000, 16'h6000);
                            w[47:32] =  rand_coef(16'h2000, 16'h6000);
                            w[63:48] = -rand_coef(16'h1000, 16'h6000);
                        end
                        default: begin
                            near_d = $urandom_range(4096);
                            far_d  = near_d + int'($urandom_range(1 << 18));
                            if ($urandom_range(7) == 0) begin
                                // inverted range now and then
                                tmp    = near_d;
                                near_d = far_d;
                                far_d  = tmp;
                            end
                            w[19:0]  = 20'(near_d);
                            w[39:20] = 20'(far_d);
                        end
                    endcase
                end
            endcase
            // keep bits above the register width clear
            cfg_write(t_cfg_addr'(r), w & ((64'h1 << cfg_widths[r]) - 64'h1));
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly mid-sized spheres ahead of the eye, one in five fully random
    function automatic t_sphere random_sphere();
        t_sphere s;
        int      span;
        if ($urandom_range(9) < 2) begin
            s.pos_x   = 20'($urandom);
            s.pos_y   = 20'($urandom);
            s.pos_z   = 20'($urandom);
            s.radius  = 19'($urandom);
            s.in_view = 1'($urandom);
        end else begin
            span      = 8 + 5 * $urandom_range(2);   // 8, 13 or 18
            s.pos_x   = 20'(int'($urandom_range(2 << span)) - (1 << span));
            s.pos_y   = 20'(int'($urandom_range(2 << span)) - (1 << span));
            s.pos_z   = 20'(int'($urandom_range(1 << (span - 2)))
                            - int'($urandom_range(1 << span)));
            s.radius  = 19'($urandom_range(1 << (span - 1)));
            s.in_view = 1'($urandom);
        end
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        cull_regs[REG_ROT_COL_X]      = ROT_COL_X_RST;
        cull_regs[REG_ROT_COL_Y]      = ROT_COL_Y_RST;
        cull_regs[REG_ROT_COL_Z]      = ROT_COL_Z_RST;
        cull_regs[REG_VIEW_TRANS]     = VIEW_TRANS_RST;
        cull_regs[REG_SIDE_PLANES_LR] = SIDE_PLANES_LR_RST;
        cull_regs[REG_SIDE_PLANES_TB] = SIDE_PLANES_TB_RST;
        cull_regs[REG_NEAR_FAR]       = NEAR_FAR_RST;

        // Directed rows. Sphere fields: x, y, z, radius, in_view.
        // Fixed verdicts only under the reset setting (identity, zero range,
        // zero planes): there a sphere shows iff |z| <= radius.
        directed_rows = '{
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, 0, 0, 1},       WANT_SHOWN},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, -256, 0, 1},    WANT_CULLED},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, 256, 0, 1},     WANT_CULLED},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, -256, 256, 1},  WANT_SHOWN},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, 256, 256, 1},   WANT_SHOWN},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0,
              '{524287, -524288, -524288, 524287, 0},                       WANT_CULLED},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0,
              '{-524288, 524287, 524287, 524287, 0},                        WANT_SHOWN},
            // 1.0 .. 100.0 range, 90 degree side planes, offset eye
            '{ROW_CFG, REG_NEAR_FAR,       64'h0000_0006_4000_0100, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_CFG, REG_SIDE_PLANES_LR, 64'hC000_4000_C000_C000, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_CFG, REG_SIDE_PLANES_TB, 64'hC000_4000_C000_C000, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_CFG, REG_VIEW_TRANS,     64'h0FFB_00FF_E000_0100, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, -2560, 0, 1},      WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{2560, 0, -2560, 0, 1},   WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{2561, 0, -2560, 0, 1},   WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, -3000, -2560, 512, 1}, WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{100, 200, 3000, 300, 0}, WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, -200, 56, 1},      WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, -25856, 256, 1},   WANT_MODEL},
            // near beyond far
            '{ROW_CFG, REG_NEAR_FAR,       64'h0000_0000_3E80_1388, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, -3000, 2000, 1},   WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, -3000, 100, 1},    WANT_MODEL},
            // write to a missing register is dropped
            '{ROW_CFG, REG_OUT_OF_RANGE,   64'hFFFF_FFFF_FFFF_FFFF, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{0, 0, -3000, 2000, 1},   WANT_MODEL},
            // coefficient and offset extremes
            '{ROW_CFG, REG_ROT_COL_X,      64'h0000_7FFF_8000_7FFF, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_CFG, REG_ROT_COL_Y,      64'h0000_8000_8000_8000, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_CFG, REG_ROT_COL_Z,      64'h0000_7FFF_7FFF_8000, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_CFG, REG_SIDE_PLANES_LR, 64'h8000_7FFF_7FFF_8000, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_CFG, REG_SIDE_PLANES_TB, 64'h7FFF_8000_8000_7FFF, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_CFG, REG_VIEW_TRANS,     64'h0FFF_FF80_0007_FFFF, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_CFG, REG_NEAR_FAR,       64'h0000_007F_FFF8_0000, '{0, 0, 0, 0, 0}, WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0,
              '{524287, 524287, 524287, 524287, 0},                           WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0,
              '{-524288, -524288, -524288, 0, 0},                             WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0, '{-524288, 524287, -1, 1, 0}, WANT_MODEL},
            '{ROW_SPHERE, REG_OUT_OF_RANGE, 64'h0,
              '{524287, -524288, 524287, 524287, 1},                          WANT_MODEL}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass under the first idle mix
        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                park_inputs();
                cfg_write(directed_rows[n].addr, directed_rows[n].data);
                i_cfg_wr_en <= 1'b0;
            end else begin
                offer_sphere(directed_rows[n].sph, directed_rows[n].want);
            end
        end

        // random pass: slow receiver, then slow sender, then full rate
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 1) ? 75 : (ph == 0) ? 9 : 0;
            recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 9 : 0;
            foreach (phase_plan[k]) begin
                load_setting(phase_plan[k]);
                repeat (ITEMS_PER_SETTING) offer_sphere(random_sphere(), WANT_MODEL);
            end
        end

        // drain, then give any stray beat time to show up
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sphere_frustum_cull_test_core.f @@
design/sfc_pkg.sv
design/sfc_xform_lane.sv
design/sphere_frustum_cull_test_core.sv
verif/tb.sv
